// ===== hw/rtl/whp_pkg.sv =====
// shared types and constants for the weather record hex parser
package whp_pkg;

	// character codes
	localparam logic [7:0] CHAR_LF   = 8'd10;
	localparam logic [7:0] CHAR_CR   = 8'd13;
	localparam logic [7:0] CHAR_BANG = 8'h21;

	// line position saturates here
	localparam logic [5:0] POS_MAX = 6'd63;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_SPEED_LIMIT    = 2'd0,
		REG_HUMIDITY_LIMIT = 2'd1,
		REG_RAIN_LIMIT     = 2'd2
	} cfg_reg_t;

	// limit reset values
	localparam logic [15:0] SPEED_LIMIT_RST    = 16'd200;
	localparam logic [15:0] HUMIDITY_LIMIT_RST = 16'd100;
	localparam logic [17:0] RAIN_LIMIT_RST     = 18'd10000;

	// reciprocal for n / 10, exact for n below 2^18, shift 19
	localparam logic [15:0] DIV10_RECIP = 16'd52429;
	// 360 / 256 reduces to 45 / 32
	localparam logic [5:0]  DIR_SCALE   = 6'd45;
	// 2.54 scaled by 2^24 and rounded up, exact for 16-bit words
	localparam logic [25:0] RAIN_RECIP  = 26'd42614129;
	// humidity rounding offset
	localparam logic [15:0] HUMID_ROUND = 16'd5;

	// completed line, as captured at newline
	typedef struct packed {
		logic        bogus;
		logic [15:0] speed_word;
		logic [7:0]  dir_byte;
		logic [15:0] humid_word;
		logic [15:0] rain_word;
	} line_rec_t;

	// scaled values of one line
	typedef struct packed {
		logic        bogus;
		logic [12:0] speed;
		logic [8:0]  dir;
		logic [12:0] humidity;
		logic [17:0] rain;
	} scaled_rec_t;

	// nibble value of an uppercase hex digit, anything else is zero
	function automatic logic [3:0] hex_digit(input logic [7:0] c);
		logic [3:0] d;
		d = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c[3:0];
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = c[3:0] + 4'd9;
		end
		return d;
	endfunction

endpackage

// ===== hw/rtl/whp_line_parser.sv =====
// input register and per-character line parsing, captures a record at newline
module whp_line_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  logic [7:0]          in_char,
	output logic                rec_valid_s2,
	output whp_pkg::line_rec_t  rec_s2
);
	import whp_pkg::*;

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic [5:0]  pos_q;
	logic        hdr_good_q;
	logic [15:0] speed_word_q;
	logic [7:0]  dir_byte_q;
	logic [15:0] humid_word_q;
	logic [15:0] rain_word_q;
	logic [3:0]  digit;
	logic        is_lf;
	logic        is_cr;

	assign digit = hex_digit(char_s1);
	assign is_lf = (char_s1 == CHAR_LF);
	assign is_cr = (char_s1 == CHAR_CR);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			char_s1 <= in_char;
		end
	end

	// line state: position, header check and hex word gathering
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			hdr_good_q   <= 1'b1;
			speed_word_q <= '0;
			dir_byte_q   <= '0;
			humid_word_q <= '0;
			rain_word_q  <= '0;
		end else if (adv && valid_s1 && !is_cr) begin
			if (is_lf) begin
				pos_q        <= '0;
				hdr_good_q   <= 1'b1;
				speed_word_q <= '0;
				dir_byte_q   <= '0;
				humid_word_q <= '0;
				rain_word_q  <= '0;
			end else begin
				if (pos_q < 6'd2 && char_s1 != CHAR_BANG) begin
					hdr_good_q <= 1'b0;
				end
				case (pos_q)
					6'd2:  speed_word_q[15:12] <= digit;
					6'd3:  speed_word_q[11:8]  <= digit;
					6'd4:  speed_word_q[7:4]   <= digit;
					6'd5:  speed_word_q[3:0]   <= digit;
					6'd8:  dir_byte_q[7:4]     <= digit;
					6'd9:  dir_byte_q[3:0]     <= digit;
					6'd26: humid_word_q[15:12] <= digit;
					6'd27: humid_word_q[11:8]  <= digit;
					6'd28: humid_word_q[7:4]   <= digit;
					6'd29: humid_word_q[3:0]   <= digit;
					6'd42: rain_word_q[15:12]  <= digit;
					6'd43: rain_word_q[11:8]   <= digit;
					6'd44: rain_word_q[7:4]    <= digit;
					6'd45: rain_word_q[3:0]    <= digit;
					default: ;
				endcase
				if (pos_q < POS_MAX) begin
					pos_q <= pos_q + 6'd1;
				end
			end
		end
	end

	// record capture at newline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_s2 <= 1'b0;
		end else if (adv) begin
			rec_valid_s2 <= valid_s1 && is_lf;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && is_lf) begin
			rec_s2.bogus      <= (pos_q < 6'd2) || !hdr_good_q;
			rec_s2.speed_word <= speed_word_q;
			rec_s2.dir_byte   <= dir_byte_q;
			rec_s2.humid_word <= humid_word_q;
			rec_s2.rain_word  <= rain_word_q;
		end
	end

endmodule

// ===== hw/rtl/whp_scaler.sv =====
// constant scaling of the captured words by reciprocal multiplication
module whp_scaler (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 rec_valid_s2,
	input  whp_pkg::line_rec_t   rec_s2,
	output logic                 scl_valid_s3,
	output whp_pkg::scaled_rec_t scl_s3
);
	import whp_pkg::*;

	logic [31:0] speed_prod;
	logic [13:0] dir_prod;
	logic [16:0] humid_sum;
	logic [32:0] humid_prod;
	logic [41:0] rain_prod;

	// speed / 10, 360 * dir / 256, (humidity + 5) / 10, 254 * rain / 100
	assign speed_prod = 32'(rec_s2.speed_word) * 32'(DIV10_RECIP);
	assign dir_prod   = 14'(rec_s2.dir_byte) * 14'(DIR_SCALE);
	assign humid_sum  = 17'(rec_s2.humid_word) + 17'(HUMID_ROUND);
	assign humid_prod = 33'(humid_sum) * 33'(DIV10_RECIP);
	assign rain_prod  = 42'(rec_s2.rain_word) * 42'(RAIN_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_valid_s3 <= 1'b0;
		end else if (adv) begin
			scl_valid_s3 <= rec_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && rec_valid_s2) begin
			scl_s3.bogus    <= rec_s2.bogus;
			scl_s3.speed    <= speed_prod[31:19];
			scl_s3.dir      <= dir_prod[13:5];
			scl_s3.humidity <= humid_prod[31:19];
			scl_s3.rain     <= rain_prod[41:24];
		end
	end

endmodule

// ===== hw/rtl/whp_held_update.sv =====
// limit checks, held values, the result register and its skid register
module whp_held_update (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 scl_valid_s3,
	input  whp_pkg::scaled_rec_t scl_s3,
	input  logic [15:0]          speed_limit,
	input  logic [15:0]          humidity_limit,
	input  logic [17:0]          rain_limit,
	input  logic                 out_ready,
	output logic                 skd_valid_q,
	output logic                 out_valid_q,
	output logic                 out_status_q,
	output logic [12:0]          out_speed_q,
	output logic [8:0]           out_dir_q,
	output logic [12:0]          out_humidity_q,
	output logic [17:0]          out_rain_q
);
	import whp_pkg::*;

	logic [12:0] held_speed_q;
	logic [8:0]  held_dir_q;
	logic [12:0] held_humidity_q;
	logic [17:0] held_rain_q;
	logic [12:0] speed_nxt;
	logic [8:0]  dir_nxt;
	logic [12:0] humidity_nxt;
	logic [17:0] rain_nxt;
	logic        skd_status_q;
	logic [12:0] skd_speed_q;
	logic [8:0]  skd_dir_q;
	logic [12:0] skd_humidity_q;
	logic [17:0] skd_rain_q;
	logic        new_valid;
	logic        out_free;

	// a new item leaves the scaling stage; the result register can take one
	assign new_valid = adv && scl_valid_s3;
	assign out_free  = !out_valid_q || out_ready;

	// a good line replaces the direction, and each other value that lies within its limit
	always_comb begin
		speed_nxt    = held_speed_q;
		dir_nxt      = held_dir_q;
		humidity_nxt = held_humidity_q;
		rain_nxt     = held_rain_q;
		if (!scl_s3.bogus) begin
			if (16'(scl_s3.speed) < speed_limit) begin
				speed_nxt = scl_s3.speed;
			end
			dir_nxt = scl_s3.dir;
			if (16'(scl_s3.humidity) <= humidity_limit) begin
				humidity_nxt = scl_s3.humidity;
			end
			if (scl_s3.rain < rain_limit) begin
				rain_nxt = scl_s3.rain;
			end
		end
	end

	// held values, result valid and skid valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_speed_q    <= '0;
			held_dir_q      <= '0;
			held_humidity_q <= '0;
			held_rain_q     <= '0;
			out_valid_q     <= 1'b0;
			skd_valid_q     <= 1'b0;
		end else begin
			if (new_valid) begin
				held_speed_q    <= speed_nxt;
				held_dir_q      <= dir_nxt;
				held_humidity_q <= humidity_nxt;
				held_rain_q     <= rain_nxt;
			end
			if (out_free) begin
				out_valid_q <= skd_valid_q || new_valid;
				skd_valid_q <= 1'b0;
			end else if (new_valid) begin
				skd_valid_q <= 1'b1;
			end
		end
	end

	// result payload, from the skid register first
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skd_valid_q) begin
				out_status_q   <= skd_status_q;
				out_speed_q    <= skd_speed_q;
				out_dir_q      <= skd_dir_q;
				out_humidity_q <= skd_humidity_q;
				out_rain_q     <= skd_rain_q;
			end else if (new_valid) begin
				out_status_q   <= scl_s3.bogus;
				out_speed_q    <= speed_nxt;
				out_dir_q      <= dir_nxt;
				out_humidity_q <= humidity_nxt;
				out_rain_q     <= rain_nxt;
			end
		end else if (new_valid) begin
			skd_status_q   <= scl_s3.bogus;
			skd_speed_q    <= speed_nxt;
			skd_dir_q      <= dir_nxt;
			skd_humidity_q <= humidity_nxt;
			skd_rain_q     <= rain_nxt;
		end
	end

endmodule

// ===== hw/rtl/weather_record_hex_parser.sv =====
// top level of the weather record hex parser
// Takes one received character per clock while s_axis_tready is high and
// returns one item per newline; carriage returns and other characters
// produce no item. The line must open with two '!' characters, after which
// hex words at fixed positions give wind speed, direction, humidity and
// rain; characters other than digits and uppercase A-F, and unreached
// positions, count as zero. The rate is one character per cycle, set by the
// four-register pipeline (input, line capture, scaling multipliers, result),
// which advances as one and stalls only while two finished items wait, one
// in the result register and one in the skid register beside it;
// s_axis_tready comes straight from that skid register. m_axis_tuser carries
// the status: 0 line accepted, 1 bad header with the held values repeated
// unchanged. Limits must be written through the cfg port while the block is
// idle; the block itself does not enforce it; index 0 speed, 1 humidity, 2 rain.
module weather_record_hex_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [17:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // wind_speed, wind_dir, humidity, rain, zero pad
	output logic [0:0]  m_axis_tuser    // [0] status
);
	import whp_pkg::*;

	logic        adv;
	logic        rec_valid_s2;
	line_rec_t   rec_s2;
	logic        scl_valid_s3;
	scaled_rec_t scl_s3;
	logic [15:0] speed_limit_q;
	logic [15:0] humidity_limit_q;
	logic [17:0] rain_limit_q;
	logic        skd_valid_q;
	logic        out_valid_q;
	logic        out_status_q;
	logic [12:0] out_speed_q;
	logic [8:0]  out_dir_q;
	logic [12:0] out_humidity_q;
	logic [17:0] out_rain_q;

	// pipeline moves unless the skid register holds a finished item
	assign adv           = !skd_valid_q;
	assign s_axis_tready = adv;

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_limit_q    <= SPEED_LIMIT_RST;
			humidity_limit_q <= HUMIDITY_LIMIT_RST;
			rain_limit_q     <= RAIN_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPEED_LIMIT:    speed_limit_q    <= cfg_data[15:0];
				REG_HUMIDITY_LIMIT: humidity_limit_q <= cfg_data[15:0];
				REG_RAIN_LIMIT:     rain_limit_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	whp_line_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_valid     (s_axis_tvalid),
		.in_char      (s_axis_tdata),
		.rec_valid_s2 (rec_valid_s2),
		.rec_s2       (rec_s2)
	);

	whp_scaler u_scaler (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.rec_valid_s2 (rec_valid_s2),
		.rec_s2       (rec_s2),
		.scl_valid_s3 (scl_valid_s3),
		.scl_s3       (scl_s3)
	);

	whp_held_update u_held (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.scl_valid_s3   (scl_valid_s3),
		.scl_s3         (scl_s3),
		.speed_limit    (speed_limit_q),
		.humidity_limit (humidity_limit_q),
		.rain_limit     (rain_limit_q),
		.out_ready      (m_axis_tready),
		.skd_valid_q    (skd_valid_q),
		.out_valid_q    (out_valid_q),
		.out_status_q   (out_status_q),
		.out_speed_q    (out_speed_q),
		.out_dir_q      (out_dir_q),
		.out_humidity_q (out_humidity_q),
		.out_rain_q     (out_rain_q)
	);

	// result packing
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {3'b000, out_rain_q, out_humidity_q, out_dir_q, out_speed_q};

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for the weather record hex parser: directed lines, then random lines
`timescale 1ns / 100ps

module tb_top;
	import whp_pkg::*;

	// printable character codes used to build lines
	localparam logic [7:0] CH_DIGIT0 = 8'h30;
	localparam logic [7:0] CH_DIGIT9 = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;

	localparam int unsigned SPEED_LIMIT_TOP = 65535;
	localparam int unsigned HUMIDITY_LIMIT_TOP = 65535;
	localparam int unsigned RAIN_LIMIT_TOP = 166459;
	localparam int PHASE_COUNT = 6;
	localparam int PHASE_CHARS = 140;
	localparam int PHASE_LINES = 3;
	localparam int SETTLE_CYCLES = 8;
	localparam int WATCHDOG_CYCLES = 4000;
	localparam int REPORT_MAX = 10;

	// one line result as it leaves the block
	typedef struct packed {
		logic        status;
		logic [12:0] speed;
		logic [8:0]  dir;
		logic [12:0] humidity;
		logic [17:0] rain;
	} line_result_t;

	// directed stimulus row, result typed in on newline rows
	typedef struct {
		logic [7:0]   ch;
		bit           has_res;
		line_result_t want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [17:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [0:0]  m_tuser;

	weather_record_hex_parser u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// line tracker state and limits
	int unsigned  lim_speed, lim_humidity, lim_rain;
	int unsigned  trk_pos;
	bit           trk_hdr_ok;
	int unsigned  trk_speed_word, trk_dir_byte, trk_humid_word, trk_rain_word;
	logic [12:0]  held_speed;
	logic [8:0]   held_dir;
	logic [12:0]  held_humidity;
	logic [17:0]  held_rain;

	line_result_t pending_lines[$];
	plan_row_t    plan[$];

	int s_idle_pct, r_idle_pct;
	int chars_sent, lines_checked, bogus_seen, fail_count;
	int phase_chars, phase_lines;

	line_result_t got_line, want_line;

	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		if (c >= CH_DIGIT0 && c <= CH_DIGIT9) begin
			return 4'(c - CH_DIGIT0);
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
			return 4'(c - CH_UPPER_A + 8'd10);
		end
		return 4'd0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) begin
			return CH_DIGIT0 + 8'(n);
		end
		return CH_UPPER_A + 8'(n) - 8'd10;
	endfunction

	task automatic clear_line();
		trk_pos = 0;
		trk_hdr_ok = 1'b1;
		trk_speed_word = 0;
		trk_dir_byte = 0;
		trk_humid_word = 0;
		trk_rain_word = 0;
	endtask

	task automatic reset_tracker();
		lim_speed = SPEED_LIMIT_RST;
		lim_humidity = HUMIDITY_LIMIT_RST;
		lim_rain = RAIN_LIMIT_RST;
		clear_line();
		held_speed = '0;
		held_dir = '0;
		held_humidity = '0;
		held_rain = '0;
	endtask

	// advance the line tracker by one character; newline yields a result
	task automatic track_char(input logic [7:0] c, output bit emitted, output line_result_t res);
		int unsigned p, v, d;
		emitted = 1'b0;
		res = '0;
		if (c == CHAR_CR) begin
			return;
		end
		if (c == CHAR_LF) begin
			res.status = (trk_pos < 2) || !trk_hdr_ok;
			if (!res.status) begin
				v = trk_speed_word / 10;
				if (v < lim_speed) held_speed = 13'(v);
				held_dir = 9'((360 * trk_dir_byte) / 256);
				v = (trk_humid_word + 5) / 10;
				if (v <= lim_humidity) held_humidity = 13'(v);
				v = (254 * trk_rain_word) / 100;
				if (v < lim_rain) held_rain = 18'(v);
			end
			res.speed = held_speed;
			res.dir = held_dir;
			res.humidity = held_humidity;
			res.rain = held_rain;
			emitted = 1'b1;
			clear_line();
			return;
		end
		if (trk_pos < 2) begin
			if (c != CHAR_BANG) trk_hdr_ok = 1'b0;
		end else begin
			p = trk_pos - 2;
			d = nibble_of(c);
			if (p < 4) begin
				trk_speed_word |= d << (4 * (3 - p));
			end else if (p == 6 || p == 7) begin
				trk_dir_byte |= d << (4 * (7 - p));
			end else if (p >= 24 && p < 28) begin
				trk_humid_word |= d << (4 * (27 - p));
			end else if (p >= 40 && p < 44) begin
				trk_rain_word |= d << (4 * (43 - p));
			end
		end
		if (trk_pos < POS_MAX) trk_pos++;
	endtask

	// offer one character, starting and ending at a falling edge
	task automatic send_char(input logic [7:0] c, input bit typed, input line_result_t typed_res);
		bit           emitted;
		line_result_t res;
		while ($urandom_range(0, 99) < s_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		do @(posedge clk); while (!s_tready);
		track_char(c, emitted, res);
		if (emitted) pending_lines.push_back(typed ? typed_res : res);
		if (c != CHAR_CR) begin
			chars_sent++;
			phase_chars++;
		end
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] c);
		send_char(c, 1'b0, '0);
	endtask

	// wait for every line result, then let the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_lines.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// three back-to-back limit writes, block idle
	task automatic set_limits(input int unsigned spd, input int unsigned hum, input int unsigned rn);
		cfg_we <= 1'b1;
		cfg_index <= REG_SPEED_LIMIT;
		cfg_data <= 18'(spd);
		@(negedge clk);
		cfg_index <= REG_HUMIDITY_LIMIT;
		cfg_data <= 18'(hum);
		@(negedge clk);
		cfg_index <= REG_RAIN_LIMIT;
		cfg_data <= 18'(rn);
		@(negedge clk);
		cfg_we <= 1'b0;
		lim_speed = spd;
		lim_humidity = hum;
		lim_rain = rn;
	endtask

	task automatic add_row(input logic [7:0] ch, input bit has_res = 1'b0,
			input bit st = 1'b0, input int spd = 0);
		plan_row_t row;
		row.ch = ch;
		row.has_res = has_res;
		row.want = '0;
		row.want.status = st;
		row.want.speed = 13'(spd);
		plan.push_back(row);
	endtask

	task automatic add_text(input string s);
		foreach (s[i]) add_row(s[i]);
	endtask

	function automatic logic [7:0] any_but_lf();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == CHAR_LF);
		return b;
	endfunction

	function automatic logic [7:0] filler();
		if ($urandom_range(0, 99) < 60) return hex_char(4'($urandom_range(0, 15)));
		return any_but_lf();
	endfunction

	// half the words full range, half up to just past the current limit
	function automatic int unsigned near_limit(input int unsigned cap);
		if (cap > 65535) cap = 65535;
		if ($urandom_range(0, 1)) return $urandom_range(0, 65535);
		return $urandom_range(0, cap);
	endfunction

	function automatic logic [7:0] payload_char(input int i, input int unsigned spd,
			input int unsigned dirb, input int unsigned hum, input int unsigned rn);
		logic [3:0] n;
		if (i < 4) n = 4'(spd >> (4 * (3 - i)));
		else if (i == 6 || i == 7) n = 4'(dirb >> (4 * (7 - i)));
		else if (i >= 24 && i < 28) n = 4'(hum >> (4 * (27 - i)));
		else if (i >= 40 && i < 44) n = 4'(rn >> (4 * (43 - i)));
		else return filler();
		// an occasional digit is replaced by any byte but newline
		if ($urandom_range(0, 99) < 6) return any_but_lf();
		return hex_char(n);
	endfunction

	// one random line: mostly well formed, some bad headers, some noise
	task automatic send_line();
		logic [7:0]  body[$];
		logic [7:0]  x;
		int          kind, len, r;
		int unsigned spd, dirb, hum, rn;
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			if (kind < 70) begin
				body.push_back(CHAR_BANG);
				body.push_back(CHAR_BANG);
			end else begin
				do x = 8'($urandom_range(0, 255));
				while (x == CHAR_LF || x == CHAR_CR || x == CHAR_BANG);
				r = $urandom_range(0, 2);
				body.push_back(r == 0 ? CHAR_BANG : x);
				body.push_back(r == 1 ? CHAR_BANG : x);
			end
			r = $urandom_range(0, 99);
			if (r < 75) len = 44 + $urandom_range(0, 4);
			else if (r < 88) len = $urandom_range(0, 43);
			else len = $urandom_range(58, 70);
			spd = near_limit(lim_speed * 10 + 40);
			hum = near_limit(lim_humidity * 10 + 40);
			rn = near_limit(lim_rain * 100 / 254 + 40);
			dirb = $urandom_range(0, 255);
			for (int i = 0; i < len; i++) body.push_back(payload_char(i, spd, dirb, hum, rn));
		end else begin
			len = $urandom_range(1, 20);
			for (int i = 0; i < len; i++) body.push_back(8'($urandom_range(0, 255)));
		end
		body.push_back(CHAR_LF);
		foreach (body[i]) begin
			if ($urandom_range(0, 99) < 4) send_byte(CHAR_CR);
			send_byte(body[i]);
		end
		phase_lines++;
	endtask

	// receiver stalls
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= r_idle_pct);
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_line.status = m_tuser[0];
			got_line.speed = m_tdata[12:0];
			got_line.dir = m_tdata[21:13];
			got_line.humidity = m_tdata[34:22];
			got_line.rain = m_tdata[52:35];
			lines_checked++;
			if (got_line.status) bogus_seen++;
			if (pending_lines.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX) begin
					$display("%0t unexpected item: st %0b spd %0d dir %0d hum %0d rain %0d",
						$realtime, got_line.status, got_line.speed, got_line.dir,
						got_line.humidity, got_line.rain);
				end
			end else begin
				want_line = pending_lines.pop_front();
				if (got_line !== want_line) begin
					fail_count++;
					if (fail_count <= REPORT_MAX) begin
						$display("%0t mismatch exp st %0b spd %0d dir %0d hum %0d rain %0d",
							$realtime, want_line.status, want_line.speed, want_line.dir,
							want_line.humidity, want_line.rain);
						$display("%0t          got st %0b spd %0d dir %0d hum %0d rain %0d",
							$realtime, got_line.status, got_line.speed, got_line.dir,
							got_line.humidity, got_line.rain);
					end
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
		end
		$display("timeout after %0d idle cycles", WATCHDOG_CYCLES);
		$display("CHECKS FAILED");
		$finish;
	end

	// main sequence
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SPEED_LIMIT;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_idle_pct = 27;
		r_idle_pct = 82;
		chars_sent = 0;
		lines_checked = 0;
		bogus_seen = 0;
		fail_count = 0;
		reset_tracker();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed lines: empty, one header char, split header, bad header,
		// speed over its limit, speed just under with a zero byte as digit
		add_row(CHAR_LF, 1'b1, 1'b1, 0);
		add_row(CHAR_BANG);
		add_row(CHAR_LF, 1'b1, 1'b1, 0);
		add_row(CHAR_BANG);
		add_row(CHAR_CR);
		add_row(CHAR_BANG);
		add_row(CHAR_LF, 1'b1, 1'b0, 0);
		add_row(8'hFF);
		add_row(CHAR_BANG);
		add_row(CHAR_LF, 1'b1, 1'b1, 0);
		add_text("!!FFFF");
		add_row(CHAR_LF, 1'b1, 1'b0, 0);
		add_text("!!07C");
		add_row(8'h00);
		add_row(CHAR_LF, 1'b1, 1'b0, 198);
		foreach (plan[i]) send_char(plan[i].ch, plan[i].has_res, plan[i].want);
		settle();

		// random phases, limits and idling change between them
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			s_idle_pct = (ph < 2) ? 27 : (ph < 4) ? 82 : 0;
			r_idle_pct = (ph < 2) ? 82 : (ph < 4) ? 27 : 0;
			case (ph)
				1: begin
					set_limits(0, 0, 0);
				end
				2: begin
					set_limits(SPEED_LIMIT_TOP, HUMIDITY_LIMIT_TOP, RAIN_LIMIT_TOP);
				end
				3, 4, 5: begin
					set_limits($urandom_range(0, SPEED_LIMIT_TOP),
						$urandom_range(0, HUMIDITY_LIMIT_TOP),
						$urandom_range(0, RAIN_LIMIT_TOP));
				end
				default: begin
				end
			endcase
			phase_chars = 0;
			phase_lines = 0;
			while (phase_chars < PHASE_CHARS || phase_lines < PHASE_LINES) send_line();
			settle();
		end

		fail_count += pending_lines.size();
		$display("covered %0d characters and %0d line items, %0d of them with a bad header",
			chars_sent, lines_checked, bogus_seen);
		$display("limits at reset, all zero, full scale and random; %0d errors", fail_count);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/whp_pkg.sv
hw/rtl/whp_line_parser.sv
hw/rtl/whp_scaler.sv
hw/rtl/whp_held_update.sv
hw/rtl/weather_record_hex_parser.sv
bench/tb_top.sv
